[src/assert_macros.svh]
// Assertion macros shared by the posting builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock while out of reset.
`define IIPB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("posting builder assertion failed");
// Condition that must never be seen while out of reset.
`define IIPB_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("posting builder forbidden condition seen");
`else
`define IIPB_ASSERT(lbl, prop)
`define IIPB_NEVER(lbl, cond)
`endif
`endif

[src/iipb_pkg.sv]
// Types and constants for the inverted index posting builder.
package iipb_pkg;

	localparam int WNUM_W    = 13;
	localparam int DOC_IN_W  = 16;
	localparam int POS_W     = 7;
	localparam int LEN_OUT_W = 8;
	localparam int DIST_W    = 13;
	localparam int STATUS_W  = 3;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	typedef enum logic {
		KIND_ADD  = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_APPENDED  = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_LIST_FULL = 3'd2,
		STAT_READ_OK   = 3'd3,
		STAT_READ_PAST = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LEN,
		BK_SCAN,
		BK_APPEND,
		BK_RDATA,
		BK_DONE
	} back_state_t;

	// classified request handed from front to back
	typedef struct packed {
		kind_t               kind;
		logic                in_range;
		logic [WNUM_W-1:0]   windex;
		logic [DOC_IN_W-1:0] doc_number;
		logic [POS_W-1:0]    entry_position;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [LEN_OUT_W-1:0] list_length;
		logic [DOC_IN_W-1:0]  doc_read;
		logic [DIST_W-1:0]    distinct_words;
	} res_t;

endpackage

[src/iipb_ram.sv]
// Generic simple dual-port RAM with registered read.
module iipb_ram #(
	parameter int WIDTH     = 16,
	parameter int ADDR_BITS = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [0:(1 << ADDR_BITS)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/iipb_front.sv]
// Front end: accepts requests, checks the word range, queues commands.
`include "assert_macros.svh"
module iipb_front import iipb_pkg::*; #(
	parameter int WORD_COUNT = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 hold,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	localparam logic [1:0] Q_DEPTH = 2'd2;

	logic [WNUM_W-1:0] word_number;
	cmd_t              cmd_in;
	cmd_t              q_mem [0:1];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign word_number = s_tdata[WNUM_W-1:0];

	always_comb begin
		cmd_in.kind           = kind_t'(s_tuser);
		cmd_in.in_range       = (word_number != '0) &&
		                        (32'(word_number) <= 32'(WORD_COUNT));
		cmd_in.windex         = word_number - WNUM_W'(1);
		cmd_in.doc_number     = s_tdata[WNUM_W +: DOC_IN_W];
		cmd_in.entry_position = s_tdata[WNUM_W + DOC_IN_W +: POS_W];
	end

	assign s_tready  = (count_q != Q_DEPTH) && !hold;
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	`IIPB_ASSERT(a_queue_bound, count_q <= Q_DEPTH)

endmodule

[src/iipb_back.sv]
// Back end: length lookup, duplicate scan, append or read, result register.
`include "assert_macros.svh"
module iipb_back import iipb_pkg::*; #(
	parameter int WORD_COUNT = 4096,
	parameter int LIST_DEPTH = 128,
	parameter int DOC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	output logic clearing,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic m_tvalid,
	input  logic m_tready,
	output res_t res
);

	localparam int WI = $clog2(WORD_COUNT);
	localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int LW = $clog2(LIST_DEPTH + 1);
	localparam int SW = (DOC_BITS < DOC_IN_W) ? DOC_BITS : DOC_IN_W;
	localparam int CW = $clog2(WORD_COUNT + 1);

	back_state_t   state_q, state_d;
	cmd_t          cmd_q;
	logic [WI-1:0] widx;
	logic [LW-1:0] len_q;
	logic [LW-1:0] k_q;
	logic [WI-1:0] clr_q;
	logic [CW-1:0] cnt_q;
	status_t       status_q;
	logic [SW-1:0] doc_q;
	logic          m_valid_q;
	res_t          res_q;

	logic          len_we;
	logic [WI-1:0] len_waddr;
	logic [LW-1:0] len_wdata;
	logic [WI-1:0] len_raddr;
	logic [LW-1:0] len_rdata;
	logic          post_we;
	logic [WI+PW-1:0] post_waddr;
	logic [SW-1:0] post_wdata;
	logic [WI+PW-1:0] post_raddr;
	logic [SW-1:0] post_rdata;

	logic          res_load;
	logic          pos_hit;
	logic          len_room;
	logic          doc_match;
	logic          scan_end;

	assign widx      = WI'(cmd_q.windex);
	assign pos_hit   = 32'(cmd_q.entry_position) < 32'(len_rdata);
	assign len_room  = 32'(len_q) < 32'(LIST_DEPTH);
	assign doc_match = (post_rdata == SW'(cmd_q.doc_number));
	assign scan_end  = (k_q == len_q);
	assign clearing  = (state_q == BK_CLEAR);

	iipb_ram #(.WIDTH(LW), .ADDR_BITS(WI)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	iipb_ram #(.WIDTH(SW), .ADDR_BITS(WI + PW)) u_post_ram (
		.clk   (clk),
		.we    (post_we),
		.waddr (post_waddr),
		.wdata (post_wdata),
		.raddr (post_raddr),
		.rdata (post_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_q == WI'(WORD_COUNT - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = cmd.in_range ? BK_LEN : BK_DONE;
				end
			end
			BK_LEN: begin
				if (cmd_q.kind == KIND_READ) begin
					state_d = pos_hit ? BK_RDATA : BK_DONE;
				end else begin
					state_d = (len_rdata == '0) ? BK_APPEND : BK_SCAN;
				end
			end
			BK_SCAN: begin
				priority if (doc_match) begin
					state_d = BK_DONE;
				end else if (scan_end) begin
					state_d = BK_APPEND;
				end
			end
			BK_APPEND: state_d = BK_DONE;
			BK_RDATA:  state_d = BK_DONE;
			BK_DONE: begin
				if (res_load) begin
					state_d = BK_IDLE;
				end
			end
			default:   state_d = BK_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		cmd_ready  = 1'b0;
		res_load   = 1'b0;
		len_we     = 1'b0;
		len_waddr  = widx;
		len_wdata  = LW'(len_q + LW'(1));
		len_raddr  = WI'(cmd.windex);
		post_we    = 1'b0;
		post_waddr = {widx, PW'(len_q)};
		post_wdata = SW'(cmd_q.doc_number);
		post_raddr = {widx, PW'(k_q)};
		unique case (state_q)
			BK_CLEAR: begin
				len_we    = 1'b1;
				len_waddr = clr_q;
				len_wdata = '0;
			end
			BK_IDLE: cmd_ready = 1'b1;
			BK_LEN: begin
				if (cmd_q.kind == KIND_READ) begin
					post_raddr = {widx, PW'(cmd_q.entry_position)};
				end
			end
			BK_APPEND: begin
				post_we = len_room;
				len_we  = len_room;
			end
			BK_DONE:  res_load = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_q     <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + WI'(1);
			end
			// an empty list means the word has never been added to
			if (state_q == BK_LEN && cmd_q.kind == KIND_ADD && len_rdata == '0) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_q    <= cmd;
					k_q      <= '0;
					len_q    <= '0;
					doc_q    <= '0;
					status_q <= (cmd.kind == KIND_READ) ? STAT_READ_PAST : STAT_LIST_FULL;
				end
			end
			BK_LEN: begin
				len_q <= len_rdata;
				k_q   <= LW'(1);
				if (cmd_q.kind == KIND_READ && !pos_hit) begin
					status_q <= STAT_READ_PAST;
				end
			end
			BK_SCAN: begin
				if (doc_match) begin
					status_q <= STAT_DUPLICATE;
				end else begin
					k_q <= k_q + LW'(1);
				end
			end
			BK_APPEND: begin
				if (len_room) begin
					len_q    <= LW'(len_q + LW'(1));
					status_q <= STAT_APPENDED;
				end else begin
					status_q <= STAT_LIST_FULL;
				end
			end
			BK_RDATA: begin
				doc_q    <= post_rdata;
				status_q <= STAT_READ_OK;
			end
			BK_DONE: begin
				if (res_load) begin
					res_q.status         <= status_q;
					res_q.list_length    <= LEN_OUT_W'(len_q);
					res_q.doc_read       <= DOC_IN_W'(doc_q);
					res_q.distinct_words <= DIST_W'(cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign res      = res_q;

	`IIPB_ASSERT(a_scan_bound, (state_q == BK_SCAN) |-> (k_q != '0 && k_q <= len_q))
	`IIPB_ASSERT(a_distinct_bound, 32'(cnt_q) <= 32'(WORD_COUNT))
	`IIPB_ASSERT(a_doc_only_on_read, (m_valid_q && res_q.doc_read != '0) |->
		(res_q.status == STAT_READ_OK))
	`IIPB_NEVER(a_no_cmd_in_clear, clearing && cmd_ready)

endmodule

[src/inverted_index_posting_builder.sv]
// Inverted index posting builder.
// One request is worked at a time; an add walks the word's list at one posting-memory
// read per cycle to look for a duplicate.
// A two-entry command queue lets requests be taken while a result waits on the output.
// After reset a clearing pass zeroes the length memory;
// s_tready stays low until it ends. Posting memory is not cleared.
module inverted_index_posting_builder import iipb_pkg::*; #(
	parameter int WORD_COUNT = 4096,
	parameter int LIST_DEPTH = 128,
	parameter int DOC_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [12:0] word_number, [28:13] doc_number, [35:29] entry_position, [39:36] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] kind: add or read
	input  logic                 s_tuser,
	// result channel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [7:0] list_length, [23:8] doc_read, [36:24] distinct_words, [39:37] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [STATUS_W-1:0]  m_tuser
);

	// front to back command path
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	// back holds the front off while the length memory is cleared
	logic clearing;
	res_t res;

	iipb_front #(.WORD_COUNT(WORD_COUNT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.hold      (clearing),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	iipb_back #(
		.WORD_COUNT (WORD_COUNT),
		.LIST_DEPTH (LIST_DEPTH),
		.DOC_BITS   (DOC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	// pack the result fields, lowest field first
	assign m_tdata = {3'b000, res.distinct_words, res.doc_read, res.list_length};
	assign m_tuser = res.status;

endmodule

[test/testbench.sv]
// Self-checking testbench for the inverted index posting builder.
module testbench;
	import iipb_pkg::*;

	localparam int WORDS       = 4096;
	localparam int DEPTH       = 128;
	localparam int RAND_ITEMS  = 1100;
	// no idling once this many items are left
	localparam int TAIL_ITEMS  = 150;
	// long receiver stall, in cycles
	localparam int LONG_HOLD   = 400;
	// timeout bound; the slowest runs come from the clear pass, long adds and stalls
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 10;

	// one request as the sender sees it
	typedef struct {
		kind_t                kind;
		logic [WNUM_W-1:0]    word_number;
		logic [DOC_IN_W-1:0]  doc_number;
		logic [POS_W-1:0]     entry_position;
		bit                   drain;       // hold back until all results are in
	} request_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	// shadow index state
	bit [DOC_IN_W-1:0] postings [int];      // key: word index * DEPTH + position
	int unsigned       list_len [WORDS];
	bit                word_hit [WORDS];
	int unsigned       words_seen;

	request_t    queued_reqs[$];
	res_t        awaited_results[$];
	request_t    cur_req;
	int          offered_cnt;
	int          item_total;
	int          sent_cnt;
	int          results_seen;
	int          mismatches;
	int          cycles;
	int          tx_gap;
	int          rx_gap;
	int          hold_left;
	int          long_holds;
	int          stat_seen [5];
	int          add_cnt;
	int          read_cnt;

	inverted_index_posting_builder #(
		.WORD_COUNT(WORDS),
		.LIST_DEPTH(DEPTH),
		.DOC_BITS  (16)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow index and return the result it must produce.
	function automatic res_t index_update(request_t r);
		res_t res;
		int   w;
		int   k;
		bit   dup;
		res = '0;
		if (r.word_number == 0 || r.word_number > WORDS) begin
			// out of range: nothing changes, length reported as zero
			res.status = (r.kind == KIND_READ) ? STAT_READ_PAST : STAT_LIST_FULL;
		end else begin
			w = r.word_number - 1;
			if (r.kind == KIND_READ) begin
				if (r.entry_position < list_len[w]) begin
					res.status   = STAT_READ_OK;
					res.doc_read = postings[w * DEPTH + r.entry_position];
				end else begin
					res.status = STAT_READ_PAST;
				end
			end else begin
				// first add marks the word seen, even if the doc is then dropped
				if (!word_hit[w]) begin
					word_hit[w] = 1'b1;
					words_seen++;
				end
				dup = 1'b0;
				for (k = 0; k < list_len[w]; k++)
					if (postings[w * DEPTH + k] == r.doc_number)
						dup = 1'b1;
				if (dup) begin
					res.status = STAT_DUPLICATE;
				end else if (list_len[w] >= DEPTH) begin
					res.status = STAT_LIST_FULL;
				end else begin
					postings[w * DEPTH + list_len[w]] = r.doc_number;
					list_len[w]++;
					res.status = STAT_APPENDED;
				end
			end
			res.list_length = LEN_OUT_W'(list_len[w]);
		end
		res.distinct_words = DIST_W'(words_seen);
		return res;
	endfunction

	task automatic push_req(kind_t kind, int wnum, int doc, int pos, bit drain);
		request_t r;
		r.kind           = kind;
		r.word_number    = WNUM_W'(wnum);
		r.doc_number     = DOC_IN_W'(doc);
		r.entry_position = POS_W'(pos);
		r.drain          = drain;
		queued_reqs.push_back(r);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch in %s at result %0d: expected %0d, got %0d",
					name, results_seen, want, got);
		end
	endtask

	// idling allowed except in every third hundred and in the tail
	function automatic bit idle_ok(int n);
		return (n < item_total - TAIL_ITEMS) && ((n / 100) % 3 != 2);
	endfunction

	// Sender: changes on the falling edge, holds a request until it is taken.
	always @(negedge clk) begin
		if (arst_n && sent_cnt == offered_cnt) begin
			if (tx_gap > 0) begin
				s_tvalid <= 1'b0;
				tx_gap--;
			end else if (queued_reqs.size() == 0 ||
					(queued_reqs[0].drain && awaited_results.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				cur_req = queued_reqs.pop_front();
				offered_cnt++;
				s_tdata <= {4'b0000, cur_req.entry_position, cur_req.doc_number,
					cur_req.word_number};
				s_tuser  <= cur_req.kind;
				s_tvalid <= 1'b1;
				if (idle_ok(sent_cnt) && $urandom_range(0, 7) == 0)
					tx_gap = $urandom_range(1, 12);
			end
		end
	end

	// Receiver: random short stalls plus two long hold-offs that back the block up.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (long_holds < 2 && results_seen >= (long_holds == 0 ? 250 : 650)) begin
			hold_left = LONG_HOLD - 1;
			long_holds++;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap--;
		end else begin
			m_tready <= 1'b1;
			if (idle_ok(results_seen) && $urandom_range(0, 7) == 0)
				rx_gap = $urandom_range(1, 12);
		end
	end

	// Monitor: on each rising edge, predict accepted requests and check results.
	always @(posedge clk) begin
		res_t want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, awaited_results.size());
			$display("CHECK FAILED");
			$finish;
		end else if (arst_n) begin
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(index_update(cur_req));
				sent_cnt++;
				if (cur_req.kind == KIND_READ)
					read_cnt++;
				else
					add_cnt++;
			end
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: status %0d data %h", m_tuser, m_tdata);
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(want.status), 32'(m_tuser));
					check_field("list_length", 32'(want.list_length), 32'(m_tdata[7:0]));
					check_field("doc_read", 32'(want.doc_read), 32'(m_tdata[23:8]));
					check_field("distinct_words", 32'(want.distinct_words),
						32'(m_tdata[36:24]));
				end
				if (m_tuser < 5)
					stat_seen[m_tuser]++;
				results_seen++;
			end
		end
	end

	initial begin
		int       hot [4];
		int       sel;
		int       doc;
		int       pos;
		int       wnum;

		// directed: field extremes, duplicates, reads past end, out-of-range words
		push_req(KIND_ADD,  1,    16'h0000, 0,   1'b0);
		push_req(KIND_ADD,  1,    16'hFFFF, 0,   1'b0);
		push_req(KIND_ADD,  1,    16'h0000, 0,   1'b0);   // duplicate
		push_req(KIND_READ, 1,    0,        0,   1'b0);
		push_req(KIND_READ, 1,    0,        1,   1'b0);
		push_req(KIND_READ, 1,    0,        2,   1'b0);   // past end
		push_req(KIND_READ, 1,    0,        127, 1'b0);
		push_req(KIND_ADD,  4096, 16'h1234, 0,   1'b0);   // top word
		push_req(KIND_READ, 4096, 0,        0,   1'b0);
		push_req(KIND_ADD,  0,    16'h0005, 0,   1'b0);   // word zero
		push_req(KIND_READ, 0,    0,        0,   1'b0);
		push_req(KIND_ADD,  8191, 16'hAAAA, 0,   1'b0);   // all ones word number
		push_req(KIND_READ, 8191, 0,        127, 1'b0);
		push_req(KIND_ADD,  4097, 16'h5555, 0,   1'b0);   // just above range
		push_req(KIND_READ, 2,    0,        0,   1'b0);   // word never added
		push_req(KIND_ADD,  2,    16'h8000, 0,   1'b0);
		push_req(KIND_READ, 2,    16'hFFFF, 0,   1'b0);   // doc ignored on read
		push_req(KIND_ADD,  1,    16'h7FFF, 127, 1'b0);   // pos ignored on add
		push_req(KIND_READ, 1,    0,        2,   1'b0);
		push_req(KIND_ADD,  4096, 16'h1234, 0,   1'b0);   // duplicate on top word
		push_req(KIND_READ, 4096, 0,        1,   1'b1);

		// random: a filler word that runs full, a few busy words, some scatter
		hot[0] = $urandom_range(3, WORDS - 1);
		hot[1] = 1;
		hot[2] = WORDS;
		hot[3] = $urandom_range(3, WORDS - 1);
		for (int i = 0; i < RAND_ITEMS; i++) begin
			sel = $urandom_range(0, 99);
			doc = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 31) : $urandom_range(0, 65535);
			pos = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 15) : $urandom_range(0, 127);
			if (sel < 20) begin
				// mostly fresh docs so the list fills, then keeps getting hit
				if ($urandom_range(0, 9) >= 3)
					doc = $urandom_range(0, 65535);
				push_req(KIND_ADD, hot[0], doc, pos, 1'b0);
			end else if (sel < 50) begin
				push_req(KIND_ADD, hot[$urandom_range(1, 3)], doc, pos, 1'b0);
			end else if (sel < 65) begin
				push_req(KIND_READ, hot[0], doc, pos, 1'b0);
			end else if (sel < 82) begin
				push_req(KIND_READ, hot[$urandom_range(1, 3)], doc, pos, 1'b0);
			end else begin
				if (sel < 95)
					wnum = $urandom_range(1, WORDS);
				else
					wnum = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(WORDS + 1, 8191);
				push_req(($urandom_range(0, 1) == 1) ? KIND_READ : KIND_ADD, wnum, doc, pos,
					1'b0);
			end
			// sender waits for the block to drain at these points
			if (i == 400 || i == 800)
				queued_reqs[queued_reqs.size() - 1].drain = 1'b1;
		end
		item_total = queued_reqs.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (queued_reqs.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);

		$display("%0d requests (%0d adds, %0d reads), %0d distinct words indexed",
			sent_cnt, add_cnt, read_cnt, words_seen);
		$display("statuses: appended %0d, duplicate %0d, full %0d, read ok %0d, past end %0d",
			stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4]);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d failures", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
